// ===== rtl/umpq_pkg.sv =====
// Shared types and codes for the unsorted minimum priority queue.
// Holds the command and response word layouts; depends on nothing.
`default_nettype none

package umpq_pkg;

    // Operation codes carried in the command word.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes carried in the response word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Width of the reported entry count.
    localparam int unsigned COUNT_W = 5;

    // One command word.
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] value;
    } cmd_t;

    // One response word.
    typedef struct packed {
        logic signed [31:0] removed_value;
        logic signed [31:0] smallest_value;
        logic               smallest_valid;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } rsp_t;

endpackage : umpq_pkg

`default_nettype wire

// ===== rtl/umpq_store.sv =====
// Entry storage for the priority queue: one write port, one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module umpq_store #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic signed [31:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic signed [31:0]      rd_data
);

    logic signed [31:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : umpq_store

`default_nettype wire

// ===== rtl/umpq_scan.sv =====
// Compare unit that takes the stored entries one per cycle while data_valid is high and keeps
// the smallest value, its position and the next smallest value. No package use.
`default_nettype none

module umpq_scan #(
    parameter int unsigned AW = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               data_valid,
    input  wire logic               first,
    input  wire logic signed [31:0] data,
    input  wire logic [AW-1:0]      idx,
    output logic signed [31:0]      best_val,
    output logic [AW-1:0]           best_idx,
    output logic signed [31:0]      second_val,
    output logic                    second_valid
);

    logic signed [31:0] best_val_reg;
    logic signed [31:0] best_val_next;
    logic [AW-1:0]      best_idx_reg;
    logic [AW-1:0]      best_idx_next;
    logic signed [31:0] second_val_reg;
    logic signed [31:0] second_val_next;
    logic               second_valid_reg;
    logic               second_valid_next;
    logic               below_best;
    logic               below_second;

    assign below_best   = data < best_val_reg;
    assign below_second = data < second_val_reg;

    // A strictly smaller value takes first place, so the earliest of equal
    // minima stays in first place and an equal value fills second place.
    always_comb
    begin
        best_val_next     = best_val_reg;
        best_idx_next     = best_idx_reg;
        second_val_next   = second_val_reg;
        second_valid_next = second_valid_reg;
        if (data_valid)
        begin
            if (first)
            begin
                best_val_next     = data;
                best_idx_next     = idx;
                second_valid_next = 1'b0;
            end
            else if (below_best)
            begin
                best_val_next     = data;
                best_idx_next     = idx;
                second_val_next   = best_val_reg;
                second_valid_next = 1'b1;
            end
            else if (!second_valid_reg || below_second)
            begin
                second_val_next   = data;
                second_valid_next = 1'b1;
            end
        end
    end

    // Control flag under reset, values as payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_valid_reg <= 1'b0;
        end
        else
        begin
            second_valid_reg <= second_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        second_val_reg <= second_val_next;
    end

    assign best_val     = best_val_reg;
    assign best_idx     = best_idx_reg;
    assign second_val   = second_val_reg;
    assign second_valid = second_valid_reg;

endmodule : umpq_scan

`default_nettype wire

// ===== rtl/unsorted_min_priority_queue.sv =====
// Unsorted minimum priority queue of up to DEPTH signed 32-bit entries. On a
// push the value is written at the end of the store and the held minimum is
// updated by one compare. On a pop a single compare unit reads the store through
// its one registered read port, one entry per cycle, finding the smallest entry
// and the next smallest, then the last entry is moved into the freed place. The
// block takes one command word at a time and raises stall until the response
// word has been taken. Pop on an empty queue and push on a full queue leave the
// contents alone and report a status code.
// Depends on umpq_pkg, umpq_store and umpq_scan.
`default_nettype none

module unsorted_min_priority_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire umpq_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output umpq_pkg::rsp_t      rsp
);

    import umpq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] min_reg;
    logic signed [31:0] min_next;
    logic               min_valid_reg;
    logic               min_valid_next;
    logic [AW-1:0]      issue_addr_reg;
    logic [AW-1:0]      issue_addr_next;
    logic               issue_busy_reg;
    logic               issue_busy_next;
    logic               cmp_valid_reg;
    logic               cmp_valid_next;
    logic [AW-1:0]      cmp_idx_reg;
    logic [AW-1:0]      cmp_idx_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    logic               cmd_take;
    logic               rsp_take;
    logic [AW-1:0]      last_idx;
    logic [CW-1:0]      count_less;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               rd_en;
    logic signed [31:0] rd_data;
    logic signed [31:0] best_val;
    logic [AW-1:0]      best_idx;
    logic signed [31:0] second_val;
    logic               second_valid;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_take   = cmd_valid && !cmd_stall;
    assign rsp_take   = rsp_valid_reg && !rsp_stall;
    assign count_less = count_reg - CW'(1);
    assign last_idx   = count_less[AW-1:0];

    umpq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_addr_reg),
        .rd_data (rd_data)
    );

    umpq_scan #(
        .AW (AW)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (cmp_valid_reg),
        .first        (cmp_idx_reg == '0),
        .data         (rd_data),
        .idx          (cmp_idx_reg),
        .best_val     (best_val),
        .best_idx     (best_idx),
        .second_val   (second_val),
        .second_valid (second_valid)
    );

    // Sequencer: push and the error cases finish at once, a pop walks the store.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        min_valid_next  = min_valid_reg;
        issue_addr_next = issue_addr_reg;
        issue_busy_next = issue_busy_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = cmd.value;
        rd_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    rsp_next.removed_value = '0;
                    rsp_next.status        = ST_OK;
                    if (cmd.opcode == OP_PUSH)
                    begin
                        if (count_reg == FULL_COUNT)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            count_next     = count_reg + CW'(1);
                            min_valid_next = 1'b1;
                            if (!min_valid_reg || (cmd.value < min_reg))
                            begin
                                min_next = cmd.value;
                            end
                        end
                        state_next     = S_DONE;
                        rsp_valid_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                        state_next      = S_DONE;
                        rsp_valid_next  = 1'b1;
                    end
                    else
                    begin
                        issue_addr_next = '0;
                        issue_busy_next = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Read one entry per cycle; compare it in the cycle after.
                if (issue_busy_reg)
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_addr_reg;
                    if (issue_addr_reg == last_idx)
                    begin
                        issue_busy_next = 1'b0;
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg + AW'(1);
                    end
                end
                if (cmp_valid_reg && (cmp_idx_reg == last_idx))
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                // The read port still holds the last entry: move it into the gap.
                wr_en                  = 1'b1;
                wr_addr                = best_idx;
                wr_data                = rd_data;
                count_next             = count_less;
                min_next               = second_val;
                min_valid_next         = second_valid;
                rsp_next.removed_value = best_val;
                state_next             = S_DONE;
                rsp_valid_next         = 1'b1;
            end

            S_DONE:
            begin
                if (rsp_take)
                begin
                    rsp_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Summary fields follow the state that the operation leaves behind.
        if (rsp_valid_next && !rsp_valid_reg)
        begin
            rsp_next.smallest_valid = min_valid_next;
            rsp_next.smallest_value = min_valid_next ? min_next : 32'sd0;
            rsp_next.entry_count    = COUNT_W'(count_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            min_valid_reg  <= 1'b0;
            issue_busy_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            min_valid_reg  <= min_valid_next;
            issue_busy_reg <= issue_busy_next;
            cmp_valid_reg  <= cmp_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        min_reg        <= min_next;
        issue_addr_reg <= issue_addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The held count never passes the store depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    // The held minimum is known exactly when entries are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        min_valid_reg == (count_reg != '0))
        else $error("minimum flag disagrees with entry count");

    // A response word is only offered in the final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (state_reg == S_DONE))
        else $error("response offered outside final state");

    // A successful pop lowers the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not remove exactly one entry");

endmodule : unsorted_min_priority_queue

`default_nettype wire

// ===== tb/sv/umpq_response_checker.sv =====
// Passive checker for the unsorted minimum priority queue: it keeps its own copy
// of the queue, predicts each response word and compares it with the block's.
// Depends on umpq_pkg.
module umpq_response_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  umpq_pkg::cmd_t cmd,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  umpq_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending_words
);

    import umpq_pkg::*;

    // Shadow copy of the queue contents, kept in push order.
    logic signed [31:0] held_values [DEPTH];
    int unsigned        held_total;

    // Response words predicted but not yet seen, oldest first.
    rsp_t               expected_rsp_q [$];
    int                 mismatches;

    // Index of the first smallest held value; held_total must be nonzero.
    function automatic int unsigned first_min_index();
        int unsigned pos;
        pos = 0;
        for (int unsigned i = 1; i < held_total; i++)
        begin
            if (held_values[i] < held_values[pos])
                pos = i;
        end
        return pos;
    endfunction

    // Apply one command word to the shadow queue and build its response word.
    function automatic rsp_t predict_queue_response(cmd_t c);
        rsp_t        r;
        int unsigned pos;
        r = '0;
        r.status = ST_OK;
        if (c.opcode == OP_PUSH)
        begin
            if (held_total >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                held_values[held_total] = c.value;
                held_total++;
            end
        end
        else if (held_total == 0)
            r.status = ST_EMPTY;
        else
        begin
            pos = first_min_index();
            r.removed_value = held_values[pos];
            for (int unsigned i = pos; i + 1 < held_total; i++)
                held_values[i] = held_values[i + 1];
            held_total--;
        end
        if (held_total > 0)
        begin
            r.smallest_value = held_values[first_min_index()];
            r.smallest_valid = 1'b1;
        end
        r.entry_count = held_total[COUNT_W-1:0];
        return r;
    endfunction

    // Check the response word first, then record the prediction for a new command.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            held_total = 0;
            expected_rsp_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_words <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response word with no command waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.removed_value !== want.removed_value)
                    begin
                        $error("removed_value: expected %0d, actual %0d",
                               want.removed_value, rsp.removed_value);
                        mismatches++;
                    end
                    if (rsp.smallest_value !== want.smallest_value)
                    begin
                        $error("smallest_value: expected %0d, actual %0d",
                               want.smallest_value, rsp.smallest_value);
                        mismatches++;
                    end
                    if (rsp.smallest_valid !== want.smallest_valid)
                    begin
                        $error("smallest_valid: expected %0d, actual %0d",
                               want.smallest_valid, rsp.smallest_valid);
                        mismatches++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, rsp.entry_count);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, rsp.status);
                        mismatches++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_rsp_q = {expected_rsp_q, predict_queue_response(cmd)};
            fail_count <= mismatches;
            pending_words <= expected_rsp_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_unsorted_min_priority_queue.sv =====
// Top of the priority queue testbench: clock, reset, command stimulus, response
// stalls, watchdog and verdict. Depends on umpq_pkg, the block and the checker.
module tb_unsorted_min_priority_queue;

    import umpq_pkg::*;

    localparam int unsigned DEPTH      = 16;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          DRAIN_WAIT = 4 * (DEPTH + 4);

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int fail_count;
    int pending_words;
    int idle_cycles = 0;

    // Longest gap each side may insert; zero gives stretches at full rate.
    int sender_max_gap     = 3;
    int receiver_max_stall = 3;

    unsorted_min_priority_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    umpq_response_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending_words(pending_words)
    );

    // Clock with a period of 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: too many cycles in a row without any word moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: hold stall high for a random number of cycles per word.
    initial
    begin
        int n;
        forever
        begin
            n = $urandom_range(0, receiver_max_stall);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    // Send one command word after a random gap and wait until it is taken.
    task automatic send_cmd(logic op, logic signed [31:0] val);
        int   gap;
        cmd_t c;
        gap = $urandom_range(0, sender_max_gap);
        c.opcode = op;
        c.value  = val;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // Wait until every predicted response word has been taken.
    task automatic wait_all_responses();
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    // Many small values so that duplicates and ties are common.
    function automatic logic signed [31:0] draw_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                v = $urandom_range(0, 16);
                v = v - 8;
            end
            4:       v = VAL_MAX;
            5:       v = VAL_MIN;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        logic signed [31:0] fill_values [16];
        int                 push_pct;
        fill_values = '{VAL_MAX, -5, VAL_MIN, 0, -1, 1, VAL_MIN, 7,
                        -5, VAL_MAX, 100, -100, 32'sh5555_5555, 32'shAAAA_AAAA, 3, -3};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on empty, fill with extremes and ties, push on full,
        // then pops that take out the tied minimum values first.
        send_cmd(OP_POP, VAL_MAX);
        foreach (fill_values[i])
            send_cmd(OP_PUSH, fill_values[i]);
        send_cmd(OP_PUSH, 42);
        send_cmd(OP_PUSH, VAL_MIN);
        repeat (4) send_cmd(OP_POP, $urandom);

        // Random phases that lean toward filling, draining, or neither.
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase % 3)
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            sender_max_gap     = (phase == 2) ? 0 : 3;
            receiver_max_stall = (phase == 2 || phase == 5) ? 0 : 3;
            if (phase == 4)
                wait_all_responses();
            repeat (50)
            begin
                if ($urandom_range(1, 100) <= push_pct)
                    send_cmd(OP_PUSH, draw_value());
                else
                    send_cmd(OP_POP, $urandom);
            end
        end
        cmd_valid <= 1'b0;

        wait_all_responses();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/umpq_pkg.sv
rtl/umpq_store.sv
rtl/umpq_scan.sv
rtl/unsorted_min_priority_queue.sv
tb/sv/umpq_response_checker.sv
tb/sv/tb_unsorted_min_priority_queue.sv
